>>> hw/rtl/gru_recurrent_cell_macros.svh
// Assertion macros shared by the checker of the recurrent cell.
`ifndef GRU_RECURRENT_CELL_MACROS_SVH
`define GRU_RECURRENT_CELL_MACROS_SVH

// Same-cycle implication, sampled on clk and disabled in reset.
`define GRU_ASSERT_IMPL(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("gru check failed");

// Next-cycle implication, sampled on clk and disabled in reset.
`define GRU_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("gru check failed");

`endif

>>> hw/rtl/gru_pkg.sv
// Package with constants, types, tables and helper functions of the recurrent cell.
package gru_pkg;

  localparam int NEURONS      = 32;
  localparam int DATA_W       = 16;
  localparam int FRAC         = DATA_W - 4;
  localparam int TABLE_DEPTH  = 1024;
  localparam int IDX_W        = $clog2(TABLE_DEPTH);
  localparam int NIDX_W       = $clog2(NEURONS);
  localparam int CNT_W        = NIDX_W + 1;
  localparam int MAT_W        = 2;
  localparam int WADDR_W      = MAT_W + 2 * NIDX_W;
  localparam int WEIGHT_DEPTH = 3 * NEURONS * NEURONS;
  localparam int STEP_W       = 3 * DATA_W;
  localparam int ACC_W        = 40;
  localparam int MUL_W        = DATA_W + 1;
  localparam int PROD_W       = 2 * MUL_W;
  localparam int CFG_IDX_W    = 4;
  localparam int CFG_DATA_W   = 8;
  localparam int ONE_VAL      = 1 << FRAC;

  // Weight matrix codes.
  localparam logic [MAT_W-1:0] MAT_CAND   = 2'd0;
  localparam logic [MAT_W-1:0] MAT_RESET  = 2'd1;
  localparam logic [MAT_W-1:0] MAT_UPDATE = 2'd2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_TRANSPOSE = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_NEURONS   = 4'd1;

  // Datapath operation codes.
  typedef logic [3:0] op_t;
  localparam op_t OP_NONE  = 4'd0;
  localparam op_t OP_INIT1 = 4'd1;
  localparam op_t OP_LUT1  = 4'd2;
  localparam op_t OP_GATE  = 4'd3;
  localparam op_t OP_WRRP  = 4'd4;
  localparam op_t OP_INIT2 = 4'd5;
  localparam op_t OP_LUT2  = 4'd6;
  localparam op_t OP_M1    = 4'd7;
  localparam op_t OP_M2    = 4'd8;
  localparam op_t OP_M3    = 4'd9;

  typedef logic signed [ACC_W-1:0] acc_t;
  typedef logic signed [DATA_W-1:0] data_t;
  typedef data_t tab_t [TABLE_DEPTH];

  // Command word from the controller to the datapath.
  typedef struct packed {
    logic              wr_weight;
    logic              wr_step;
    logic              clr_hid;
    logic              mac;
    logic              tag;
    logic              transpose;
    logic [MAT_W-1:0]  mat;
    logic [NIDX_W-1:0] elem;
    logic [NIDX_W-1:0] n;
    logic [NIDX_W-1:0] j;
    op_t               op;
  } dp_cmd_t;

  // Long division of nonnegative values by shift and subtract, for table building only.
  function automatic longint cdiv(input longint num, input longint den);
    longint quo;
    longint rem;
    quo = 0;
    rem = 0;
    for (int b = 62; b >= 0; b--) begin
      rem = (rem <<< 1) | ((num >>> b) & longint'(1));
      quo = quo <<< 1;
      if (rem >= den) begin
        rem = rem - den;
        quo = quo | longint'(1);
      end
    end
    return quo;
  endfunction

  // Builds the sigmoid or tanh table at elaboration from a Taylor series of e^-step.
  function automatic tab_t build_tab(input logic want_tanh);
    tab_t   t;
    longint q30;
    longint one;
    longint s;
    longint term;
    longint p;
    longint pw;
    longint den;
    longint th;
    int     half;
    int     k;
    q30  = longint'(1) << 30;
    one  = longint'(ONE_VAL);
    s    = (16 * q30) >>> IDX_W;
    term = q30;
    p    = q30;
    pw   = q30;
    half = TABLE_DEPTH >> 1;
    for (int n = 1; n <= 12; n++) begin
      term = cdiv(term * s, longint'(n) * q30);
      if (n[0]) p = p - term;
      else p = p + term;
    end
    for (int j = 0; j <= TABLE_DEPTH; j++) begin
      den = q30 + pw;
      if (!want_tanh) begin
        if (j <= half) begin
          if (half + j < TABLE_DEPTH) t[half + j] = DATA_W'(cdiv(one * q30 + (den >>> 1), den));
          t[half - j] = DATA_W'(cdiv(one * pw + (den >>> 1), den));
        end
      end else if (!j[0] && ((j >> 1) <= half)) begin
        k  = j >> 1;
        th = cdiv(one * (q30 - pw) + (den >>> 1), den);
        if (half + k < TABLE_DEPTH) t[half + k] = DATA_W'(th);
        t[half - k] = DATA_W'(-th);
      end
      pw = (pw * p + (q30 >>> 1)) >>> 30;
    end
    return t;
  endfunction

  localparam tab_t SIG_TAB  = build_tab(1'b0);
  localparam tab_t TANH_TAB = build_tab(1'b1);

  // Round half up, shift out the fraction and saturate to the data width.
  function automatic data_t rnd_sat(input acc_t v);
    acc_t q;
    acc_t hi;
    acc_t lo;
    data_t res;
    hi = ACC_W'((2 ** (DATA_W - 1)) - 1);
    lo = -hi - ACC_W'(1);
    q  = (v + (ACC_W'(1) <<< (FRAC - 1))) >>> FRAC;
    if (q > hi) res = hi[DATA_W-1:0];
    else if (q < lo) res = lo[DATA_W-1:0];
    else res = q[DATA_W-1:0];
    return res;
  endfunction

  // Table index: the offset-binary value truncated to its top bits.
  function automatic logic [IDX_W-1:0] lut_idx(input data_t v);
    return {~v[DATA_W-1], v[DATA_W-2 -: IDX_W-1]};
  endfunction

endpackage

>>> hw/rtl/gru_in_if.sv
// Input channel interface: weight writes and sample elements.
interface gru_in_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [1:0]  weight_matrix;
  logic [4:0]  weight_row;
  logic [4:0]  weight_col;
  logic signed [15:0] weight_value;
  logic signed [15:0] x_in;
  logic signed [15:0] xr_in;
  logic signed [15:0] xz_in;
  logic        seq_start;

  modport source (output valid, kind, weight_matrix, weight_row, weight_col, weight_value,
                  x_in, xr_in, xz_in, seq_start, input ready);
  modport sink (input valid, kind, weight_matrix, weight_row, weight_col, weight_value,
                x_in, xr_in, xz_in, seq_start, output ready);
endinterface

>>> hw/rtl/gru_out_if.sv
// Result channel interface: one new neuron output per word.
interface gru_out_if;
  logic        valid;
  logic        ready;
  logic [4:0]  neuron_index;
  logic signed [15:0] y_out;
  logic        last;

  modport source (output valid, neuron_index, y_out, last, input ready);
  modport sink (input valid, neuron_index, y_out, last, output ready);
endinterface

>>> hw/rtl/gru_cfg_if.sv
// Configuration write channel interface.
interface gru_cfg_if;
  logic       valid;
  logic       ready;
  logic [3:0] index;
  logic [7:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

>>> hw/rtl/gru_recurrent_cell.sv
// Gated recurrent unit cell top level: controller plus datapath.
// A weight word or a non-final sample word is taken in the idle state, which the block does not leave for it.
// The final sample word of a step starts the work on the N neurons in use, one output
// word per neuron included; all products go through the single shared multiply-accumulate
// and its weight memory port.
// One output word leaves per neuron, stalling the sequencer while it waits.
// Synchronous active-low reset returns control and configuration to their defaults and clears hidden-state valid bits.
module gru_recurrent_cell (
  input  logic      clk,
  input  logic      rst_n,
  gru_in_if.sink    in_if,
  gru_out_if.source out_if,
  gru_cfg_if.sink   cfg_if
);
  import gru_pkg::*;

  dp_cmd_t cmd;

  gru_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_if.valid), .in_ready(in_if.ready),
    .in_kind(in_if.kind), .in_weight_matrix(in_if.weight_matrix),
    .in_seq_start(in_if.seq_start),
    .cfg_valid(cfg_if.valid), .cfg_ready(cfg_if.ready),
    .cfg_index(cfg_if.index), .cfg_data(cfg_if.data),
    .out_valid(out_if.valid), .out_ready(out_if.ready),
    .out_neuron_index(out_if.neuron_index), .out_last(out_if.last),
    .cmd(cmd)
  );

  gru_dp u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd),
    .weight_matrix(in_if.weight_matrix), .weight_row(in_if.weight_row),
    .weight_col(in_if.weight_col), .weight_value(in_if.weight_value),
    .x_in(in_if.x_in), .xr_in(in_if.xr_in), .xz_in(in_if.xz_in),
    .y_out(out_if.y_out)
  );
endmodule

>>> hw/rtl/gru_ram.sv
// Generic single-write, single-read RAM with registered read data.
module gru_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

>>> hw/rtl/gru_dp.sv
// Datapath: memories, shared multiply-accumulate, activation tables and output register.
module gru_dp (
  input  logic                    clk,
  input  logic                    rst_n,
  input  gru_pkg::dp_cmd_t        cmd,
  input  logic [1:0]              weight_matrix,
  input  logic [4:0]              weight_row,
  input  logic [4:0]              weight_col,
  input  logic signed [15:0]      weight_value,
  input  logic signed [15:0]      x_in,
  input  logic signed [15:0]      xr_in,
  input  logic signed [15:0]      xz_in,
  output logic signed [15:0]      y_out
);
  import gru_pkg::*;

  logic [WADDR_W-1:0] w_waddr;
  logic [WADDR_W-1:0] w_raddr;
  logic [NIDX_W-1:0]  row;
  logic [NIDX_W-1:0]  col;
  logic [DATA_W-1:0]  w_q;
  logic [STEP_W-1:0]  step_q;
  logic [DATA_W-1:0]  hid_q;
  logic [DATA_W-1:0]  rp_q;
  logic [DATA_W-1:0]  ug_q;
  logic [NIDX_W-1:0]  hid_raddr;
  logic [NEURONS-1:0] hvalid_r;
  logic               hv_q_r;
  data_t              hid_val;
  data_t              x_q;
  data_t              xr_q;
  data_t              xz_q;
  logic               v1_r;
  logic               t1_r;
  logic               s1_r;
  logic               v2_r;
  logic               t2_r;
  logic signed [MUL_W-1:0]  ma;
  logic signed [MUL_W-1:0]  mb;
  logic signed [PROD_W-1:0] prod_r;
  acc_t               acc_a_r;
  acc_t               acc_b_r;
  data_t              sig_r_r;
  data_t              sig_z_r;
  data_t              z_r;
  data_t              y_r;
  data_t              c_r;
  data_t              y_new;
  data_t              y_out_r;
  logic               hid_we;
  logic               rp_we;
  logic               ug_we;

  // Weight addressing follows the transpose setting.
  assign row     = cmd.transpose ? cmd.j : cmd.n;
  assign col     = cmd.transpose ? cmd.n : cmd.j;
  assign w_raddr = {cmd.mat, row, col};
  assign w_waddr = {weight_matrix, weight_row, weight_col};

  gru_ram #(.WIDTH(DATA_W), .DEPTH(WEIGHT_DEPTH)) u_wram (
    .clk(clk), .we(cmd.wr_weight), .waddr(w_waddr), .wdata(weight_value),
    .raddr(w_raddr), .rdata(w_q)
  );

  gru_ram #(.WIDTH(STEP_W), .DEPTH(NEURONS)) u_step (
    .clk(clk), .we(cmd.wr_step), .waddr(cmd.elem), .wdata({x_in, xr_in, xz_in}),
    .raddr(cmd.n), .rdata(step_q)
  );

  // Hidden vector: read at the column during gate products, else at the neuron.
  assign hid_raddr = (cmd.mac && cmd.mat != MAT_CAND) ? cmd.j : cmd.n;
  assign hid_we    = (cmd.op == OP_M3);

  gru_ram #(.WIDTH(DATA_W), .DEPTH(NEURONS)) u_hid (
    .clk(clk), .we(hid_we), .waddr(cmd.n), .wdata(y_new),
    .raddr(hid_raddr), .rdata(hid_q)
  );

  assign rp_we = (cmd.op == OP_WRRP);

  gru_ram #(.WIDTH(DATA_W), .DEPTH(NEURONS)) u_rp (
    .clk(clk), .we(rp_we), .waddr(cmd.n), .wdata(rnd_sat(ACC_W'(prod_r))),
    .raddr(cmd.j), .rdata(rp_q)
  );

  assign ug_we = (cmd.op == OP_GATE);

  gru_ram #(.WIDTH(DATA_W), .DEPTH(NEURONS)) u_ug (
    .clk(clk), .we(ug_we), .waddr(cmd.n), .wdata(sig_z_r),
    .raddr(cmd.n), .rdata(ug_q)
  );

  // Valid bits of the hidden vector; an entry not yet written reads as zero.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hvalid_r <= '0;
      hv_q_r   <= 1'b0;
    end else begin
      hv_q_r <= hvalid_r[hid_raddr];
      if (cmd.clr_hid) hvalid_r <= '0;
      else if (hid_we) hvalid_r[cmd.n] <= 1'b1;
    end
  end

  assign hid_val = hv_q_r ? data_t'(hid_q) : '0;
  assign x_q     = step_q[3*DATA_W-1 -: DATA_W];
  assign xr_q    = step_q[2*DATA_W-1 -: DATA_W];
  assign xz_q    = step_q[DATA_W-1:0];

  // Product pipeline tags: read stage, then product stage.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      v1_r <= cmd.mac;
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    t1_r <= cmd.tag;
    s1_r <= (cmd.mat == MAT_CAND);
    t2_r <= t1_r;
  end

  // Operand selection for the shared multiplier.
  always_comb begin
    ma = '0;
    mb = '0;
    if (v1_r) begin
      ma = MUL_W'(data_t'(w_q));
      mb = s1_r ? MUL_W'(data_t'(rp_q)) : MUL_W'(hid_val);
    end else begin
      case (cmd.op)
        OP_GATE: begin
          ma = MUL_W'(sig_r_r);
          mb = MUL_W'(hid_val);
        end
        OP_M1: begin
          ma = MUL_W'(z_r);
          mb = MUL_W'(y_r);
        end
        OP_M2: begin
          ma = MUL_W'(ONE_VAL) - MUL_W'(z_r);
          mb = MUL_W'(c_r);
        end
        default: begin
          ma = '0;
          mb = '0;
        end
      endcase
    end
  end

  assign y_new = rnd_sat(acc_b_r + ACC_W'(prod_r));

  // Product register, accumulators and per-neuron result registers.
  always_ff @(posedge clk) begin
    prod_r <= ma * mb;
    if (v2_r) begin
      if (t2_r) acc_b_r <= acc_b_r + ACC_W'(prod_r);
      else acc_a_r <= acc_a_r + ACC_W'(prod_r);
    end
    case (cmd.op)
      OP_INIT1: begin
        acc_a_r <= ACC_W'(xr_q) <<< FRAC;
        acc_b_r <= ACC_W'(xz_q) <<< FRAC;
      end
      OP_LUT1: begin
        sig_r_r <= SIG_TAB[lut_idx(rnd_sat(acc_a_r))];
        sig_z_r <= SIG_TAB[lut_idx(rnd_sat(acc_b_r))];
      end
      OP_INIT2: begin
        acc_a_r <= ACC_W'(x_q) <<< FRAC;
        z_r     <= data_t'(ug_q);
        y_r     <= hid_val;
      end
      OP_LUT2: c_r <= TANH_TAB[lut_idx(rnd_sat(acc_a_r))];
      OP_M2:   acc_b_r <= ACC_W'(prod_r);
      OP_M3:   y_out_r <= y_new;
      default: ;
    endcase
  end

  assign y_out = y_out_r;
endmodule

>>> hw/rtl/gru_ctrl.sv
// Controller: handshakes, configuration registers and the step sequencer.
module gru_ctrl (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic                            in_kind,
  input  logic [1:0]                      in_weight_matrix,
  input  logic                            in_seq_start,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [gru_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [gru_pkg::CFG_DATA_W-1:0]  cfg_data,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [4:0]                      out_neuron_index,
  output logic                            out_last,
  output gru_pkg::dp_cmd_t                cmd
);
  import gru_pkg::*;

  localparam logic [4:0] S_IDLE     = 5'd0;
  localparam logic [4:0] S_START    = 5'd1;
  localparam logic [4:0] S_P1_LOAD  = 5'd2;
  localparam logic [4:0] S_P1_INIT  = 5'd3;
  localparam logic [4:0] S_P1_MAC   = 5'd4;
  localparam logic [4:0] S_P1_DRAIN = 5'd5;
  localparam logic [4:0] S_P1_LUT   = 5'd6;
  localparam logic [4:0] S_P1_GATE  = 5'd7;
  localparam logic [4:0] S_P1_WRRP  = 5'd8;
  localparam logic [4:0] S_P2_LOAD  = 5'd9;
  localparam logic [4:0] S_P2_INIT  = 5'd10;
  localparam logic [4:0] S_P2_MAC   = 5'd11;
  localparam logic [4:0] S_P2_DRAIN = 5'd12;
  localparam logic [4:0] S_P2_LUT   = 5'd13;
  localparam logic [4:0] S_P2_M1    = 5'd14;
  localparam logic [4:0] S_P2_M2    = 5'd15;
  localparam logic [4:0] S_P2_M3    = 5'd16;
  localparam logic [4:0] S_EMIT     = 5'd17;

  logic [4:0]        state_r, state_nxt;
  logic              transpose_r;
  logic [CNT_W-1:0]  nu_r;
  logic [CNT_W-1:0]  elem_r, elem_nxt;
  logic              first_r, first_nxt;
  logic [NIDX_W-1:0] n_r, n_nxt;
  logic [CNT_W-1:0]  k_r, k_nxt;
  logic              drain_r, drain_nxt;
  logic [CNT_W-1:0]  cnt;
  logic [NIDX_W-1:0] elem_idx;
  logic [CNT_W-1:0]  elem_inc;
  logic              in_acc;
  logic              last_n;
  logic [CNT_W-1:0]  k_end1;
  logic [CNT_W-1:0]  k_end2;

  // Active neuron count: zero acts as one, oversize acts as the full layer.
  always_comb begin
    if (nu_r == '0) cnt = CNT_W'(1);
    else if (nu_r > CNT_W'(NEURONS)) cnt = CNT_W'(NEURONS);
    else cnt = nu_r;
  end

  assign elem_idx = (elem_r >= cnt) ? '0 : elem_r[NIDX_W-1:0];
  assign elem_inc = CNT_W'(elem_idx) + CNT_W'(1);
  assign in_ready = (state_r == S_IDLE);
  assign in_acc   = in_valid && in_ready;
  assign last_n   = (CNT_W'(n_r) == cnt - CNT_W'(1));
  assign k_end1   = CNT_W'((CNT_W + 1)'(cnt) * 2 - 1);
  assign k_end2   = cnt - CNT_W'(1);
  assign cfg_ready = 1'b1;

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      transpose_r <= 1'b0;
      nu_r        <= CNT_W'(NEURONS);
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_TRANSPOSE: transpose_r <= cfg_data[0];
        CFG_NEURONS:   nu_r <= cfg_data[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  // Sequencer next state and datapath commands.
  always_comb begin
    state_nxt = state_r;
    elem_nxt  = elem_r;
    first_nxt = first_r;
    n_nxt     = n_r;
    k_nxt     = k_r;
    drain_nxt = drain_r;
    cmd           = '0;
    cmd.transpose = transpose_r;
    cmd.n         = n_r;
    cmd.elem      = elem_idx;
    out_valid     = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          if (!in_kind) begin
            cmd.wr_weight = (in_weight_matrix inside {MAT_CAND, MAT_RESET, MAT_UPDATE});
          end else begin
            cmd.wr_step = 1'b1;
            if (in_seq_start) first_nxt = 1'b1;
            if (elem_inc == cnt) begin
              elem_nxt  = '0;
              state_nxt = S_START;
            end else begin
              elem_nxt = elem_inc;
            end
          end
        end
      end
      S_START: begin
        cmd.clr_hid = first_r;
        first_nxt   = 1'b0;
        n_nxt       = '0;
        state_nxt   = S_P1_LOAD;
      end
      S_P1_LOAD: state_nxt = S_P1_INIT;
      S_P1_INIT: begin
        cmd.op    = OP_INIT1;
        k_nxt     = '0;
        state_nxt = S_P1_MAC;
      end
      S_P1_MAC: begin
        cmd.mac = 1'b1;
        cmd.tag = k_r[0];
        cmd.mat = k_r[0] ? MAT_UPDATE : MAT_RESET;
        cmd.j   = k_r[CNT_W-1:1];
        k_nxt   = k_r + CNT_W'(1);
        if (k_r == k_end1) begin
          drain_nxt = 1'b0;
          state_nxt = S_P1_DRAIN;
        end
      end
      S_P1_DRAIN: begin
        drain_nxt = 1'b1;
        if (drain_r) state_nxt = S_P1_LUT;
      end
      S_P1_LUT: begin
        cmd.op    = OP_LUT1;
        state_nxt = S_P1_GATE;
      end
      S_P1_GATE: begin
        cmd.op    = OP_GATE;
        state_nxt = S_P1_WRRP;
      end
      S_P1_WRRP: begin
        cmd.op = OP_WRRP;
        if (last_n) begin
          n_nxt     = '0;
          state_nxt = S_P2_LOAD;
        end else begin
          n_nxt     = n_r + NIDX_W'(1);
          state_nxt = S_P1_LOAD;
        end
      end
      S_P2_LOAD: state_nxt = S_P2_INIT;
      S_P2_INIT: begin
        cmd.op    = OP_INIT2;
        k_nxt     = '0;
        state_nxt = S_P2_MAC;
      end
      S_P2_MAC: begin
        cmd.mac = 1'b1;
        cmd.mat = MAT_CAND;
        cmd.j   = k_r[NIDX_W-1:0];
        k_nxt   = k_r + CNT_W'(1);
        if (k_r == k_end2) begin
          drain_nxt = 1'b0;
          state_nxt = S_P2_DRAIN;
        end
      end
      S_P2_DRAIN: begin
        drain_nxt = 1'b1;
        if (drain_r) state_nxt = S_P2_LUT;
      end
      S_P2_LUT: begin
        cmd.op    = OP_LUT2;
        state_nxt = S_P2_M1;
      end
      S_P2_M1: begin
        cmd.op    = OP_M1;
        state_nxt = S_P2_M2;
      end
      S_P2_M2: begin
        cmd.op    = OP_M2;
        state_nxt = S_P2_M3;
      end
      S_P2_M3: begin
        cmd.op    = OP_M3;
        state_nxt = S_EMIT;
      end
      S_EMIT: begin
        out_valid = 1'b1;
        if (out_ready) begin
          if (last_n) begin
            state_nxt = S_IDLE;
          end else begin
            n_nxt     = n_r + NIDX_W'(1);
            state_nxt = S_P2_LOAD;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
    // A neuron count write drops a partly received step.
    if (cfg_valid && cfg_index == CFG_NEURONS) elem_nxt = '0;
  end

  // Sequencer registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      elem_r  <= '0;
      first_r <= 1'b1;
      n_r     <= '0;
      k_r     <= '0;
      drain_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      elem_r  <= elem_nxt;
      first_r <= first_nxt;
      n_r     <= n_nxt;
      k_r     <= k_nxt;
      drain_r <= drain_nxt;
    end
  end

  assign out_neuron_index = n_r;
  assign out_last         = last_n;
endmodule

>>> hw/rtl/gru_chk.sv
// Port-level checker of the recurrent cell and its bind to the top level.
`include "gru_recurrent_cell_macros.svh"

module gru_chk (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input logic              out_last,
  input logic [4:0]        neuron_index,
  input logic signed [15:0] y_out
);
  // A stalled output word keeps its contents.
  `GRU_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(y_out) && $stable(neuron_index))
  // No new word is taken while a result is offered.
  `GRU_ASSERT_IMPL(a_no_in_during_out, out_valid, !in_ready)
  // An accepted input word is never answered in the next cycle.
  `GRU_ASSERT_NEXT(a_no_early_out, in_valid && in_ready, !out_valid)
  // The block stays busy between the words of one step.
  `GRU_ASSERT_NEXT(a_busy_mid_step, out_valid && out_ready && !out_last, !in_ready)
endmodule

bind gru_recurrent_cell gru_chk u_chk (
  .clk(clk), .rst_n(rst_n),
  .in_valid(in_if.valid), .in_ready(in_if.ready),
  .out_valid(out_if.valid), .out_ready(out_if.ready), .out_last(out_if.last),
  .neuron_index(out_if.neuron_index), .y_out(out_if.y_out)
);
